>>> hw/rtl/uefb_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the tape image to bit stream converter
// no dependencies
package uefb_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	// action selector on the input channel
	localparam logic [1:0] ACT_BYTE = 2'd0;
	localparam logic [1:0] ACT_PULL = 2'd1;
	localparam logic [1:0] ACT_EOF  = 2'd2;

	localparam logic [15:0] ID_TAPE  = 16'h0100;
	localparam logic [15:0] ID_TONE  = 16'h0110;
	localparam logic [15:0] ID_DUMMY = 16'h0111;
	localparam logic [15:0] ID_GAP   = 16'h0112;

	localparam logic [3:0] HEADER_BYTES     = 4'd12;
	localparam logic [3:0] MAGIC_BYTES      = 4'd10;
	localparam logic [3:0] FRAME_BITS       = 4'd10;
	localparam logic [4:0] DUMMY_FRAME_BITS = 5'd20;
	localparam logic [7:0] MARK_BYTE        = 8'h41;

	// bits = ms*1000/832 = ms + floor(((21*ms) >> 3) / 13)
	localparam logic [18:0] RECIP_MUL   = 19'd322639;
	localparam int          RECIP_SHIFT = 22;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_ID,
		PH_LEN,
		PH_DATA,
		PH_DUR,
		PH_SKIP,
		PH_DEAD
	} phase_t;

	typedef enum logic [1:0] {
		RUN_NONE,
		RUN_ZERO,
		RUN_ONE,
		RUN_DUMMY
	} run_t;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_PULL,
		OP_EOF,
		OP_BAD
	} op_t;

	typedef enum logic [2:0] {
		ST_TAKEN,
		ST_VALID,
		ST_NEED,
		ST_BUSY,
		ST_HDR_BAD,
		ST_EXHAUSTED
	} stat_t;

	typedef enum logic [1:0] {
		CV_ZERO,
		CV_ONE,
		CV_PRE,
		CV_DUMMY
	} cvt_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} entry_t;

	function automatic logic [7:0] magic_byte(input logic [3:0] i);
		logic [7:0] v;
		unique case (i)
			4'd0: v = 8'h55;
			4'd1: v = 8'h45;
			4'd2: v = 8'h46;
			4'd3: v = 8'h20;
			4'd4: v = 8'h46;
			4'd5: v = 8'h69;
			4'd6: v = 8'h6C;
			4'd7: v = 8'h65;
			4'd8: v = 8'h21;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/uef_chunk_to_tape_bitstream_top.sv
`timescale 1ns / 1ps
// tape image to cassette bit stream converter, top level
// depends on uefb_pkg, uefb_front, uefb_back
//
// input channel s_*: one transfer per action. s_tuser selects deliver file byte,
// pull one output byte or end of file; s_tdata carries the file byte.
// output channel m_*: exactly one transfer per input transfer, in order.
// m_tuser is the status, m_tdata the packed stream byte (first bit in bit 7),
// m_tlast marks the final stream byte after end of file, padded if it is partial.
// throughput: one action per cycle while the output register can take a result. a file
// byte that completes a duration word holds the next action back while the ms to bit count
// multiplier pipeline finishes.
// an input transfer reaches output valid through the queue, then the output register.
// the input queue holds QUEUE_DEPTH actions (2 or more), so input keeps flowing while
// a result waits on m_tready; when the receiver stalls the queue fills and s_tready drops.
// reset: parser back in file header phase, queue empty, no pending bits, no output.
module uef_chunk_to_tape_bitstream_top #(
	parameter int QUEUE_DEPTH = uefb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // file_byte
	input  logic [1:0] s_tuser,   // action
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [2:0] m_tuser,   // status
	output logic       m_tlast    // last
);
	import uefb_pkg::*;

	logic   q_valid;
	logic   q_pop;
	entry_t q_entry;

	uefb_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop)
	);

	uefb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

`ifndef SYNTHESIS
	a_push_seen: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !q_valid |=> q_valid)
		else $error("transfer into empty queue not visible");

	a_full_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_valid)
		else $error("queue refuses input while empty");

	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> m_tvalid)
		else $error("executed action produced no result");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == ST_VALID)
		else $error("last marked on a result without data");
`endif

endmodule

>>> hw/rtl/uefb_front.sv
`timescale 1ns / 1ps
// input side: takes stream transfers, classifies the action, holds them in a short queue
// depends on uefb_pkg
module uefb_front #(
	parameter int DEPTH = uefb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // file_byte
	input  logic [1:0]       s_tuser,   // action
	output logic             q_valid,
	output uefb_pkg::entry_t q_entry,
	input  logic             q_pop
);
	import uefb_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	op_t           cls;

	always_comb begin
		unique case (s_tuser)
			ACT_BYTE: cls = OP_BYTE;
			ACT_PULL: cls = OP_PULL;
			ACT_EOF:  cls = OP_EOF;
			default:  cls = OP_BAD;
		endcase
	end

	assign s_tready = count_q != CW'(DEPTH);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = count_q != '0;
	assign q_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{op: cls, data: s_tdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/uefb_back.sv
`timescale 1ns / 1ps
// execution side: chunk parser, bit generator, byte packer and output register
// depends on uefb_pkg
module uefb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  uefb_pkg::entry_t q_entry,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // out_byte
	output logic [2:0]       m_tuser,   // status
	output logic             m_tlast    // last
);
	import uefb_pkg::*;

	// parser state
	phase_t      phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [15:0] id_q, id_d;
	logic [31:0] left_q, left_d;
	logic [15:0] dur_q, dur_d;
	logic        ended_q, ended_d;

	// bit sources and packer
	logic [9:0]  frame_q, frame_d;
	logic [3:0]  frame_left_q, frame_left_d;
	run_t        run_kind_q, run_kind_d;
	logic [17:0] run_pos_q, run_pos_d;
	logic [17:0] run_len_q;
	logic [16:0] pre_q;
	logic [7:0]  pack_q, pack_d;
	logic [2:0]  pack_cnt_q, pack_cnt_d;

	// duration conversion pipeline
	logic        conv_v_s1, conv_v_s2;
	logic [15:0] conv_ms_s1, conv_ms_s2;
	logic [17:0] conv_t_s1;
	logic [36:0] conv_prod_s2;
	cvt_t        conv_tgt_s1, conv_tgt_s2;
	logic        cv_start;
	cvt_t        cv_tgt;
	logic [15:0] cv_ms;
	logic [20:0] cv_t21;
	logic [16:0] cv_bits;
	logic [17:0] cv_dummy_len;

	// output register
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	stat_t       m_tuser_q;
	logic        m_tlast_q;

	logic [7:0]  b;
	logic        dead, pending, byte_ok, hdr_fail;
	logic [3:0]  idx_inc;
	logic [31:0] len_new;
	logic [31:0] left_dec;

	// pull datapath
	logic [3:0]  need, kf, rem, kr, tk, cnt_new, frame_left_new;
	logic        run_act, run_done, pend_after, full;
	logic [17:0] avail, pos_new;
	logic [7:0]  run_bit, slot, acc, pad;

	stat_t       res_stat;
	logic [7:0]  res_byte;
	logic        res_last;

	assign b        = q_entry.data;
	assign dead     = phase_q == PH_DEAD;
	assign run_act  = run_kind_q != RUN_NONE;
	assign pending  = frame_left_q != 4'd0 || run_act;
	assign byte_ok  = q_entry.op == OP_BYTE && !ended_q && !pending;
	assign idx_inc  = idx_q + 4'd1;
	assign hdr_fail = phase_q == PH_HEADER && idx_q < MAGIC_BYTES && b != magic_byte(idx_q);
	assign len_new  = left_q | ({24'd0, b} << {idx_q[1:0], 3'b000});
	assign left_dec = left_q - 32'd1;

	assign q_pop = q_valid && (!m_tvalid_q || m_tready) && !conv_v_s1 && !conv_v_s2;

	// bits available from the frame and the run
	assign need           = 4'd8 - {1'b0, pack_cnt_q};
	assign kf             = (frame_left_q < need) ? frame_left_q : need;
	assign rem            = need - kf;
	assign avail          = run_len_q - run_pos_q;
	assign kr             = !run_act ? 4'd0 : (avail < 18'(rem)) ? avail[3:0] : rem;
	assign tk             = kf + kr;
	assign cnt_new        = {1'b0, pack_cnt_q} + tk;
	assign frame_left_new = frame_left_q - kf;
	assign pos_new        = run_pos_q + 18'(kr);
	assign run_done       = run_act && pos_new >= run_len_q;
	assign pend_after     = frame_left_new != 4'd0 || (run_act && !run_done);
	assign full           = cnt_new == 4'd8;
	assign pad            = acc << (4'd8 - cnt_new);

	always_comb begin
		logic [18:0] pos_j;
		logic [18:0] off_j;
		logic [4:0]  q;
		logic [4:0]  qm;
		logic        dummy_bit;
		logic [3:0]  sel;
		for (int j = 0; j < 8; j++) begin
			pos_j = {1'b0, run_pos_q} + 19'(j);
			off_j = pos_j - {2'b00, pre_q};
			q     = (off_j[4:0] >= 5'(FRAME_BITS)) ? off_j[4:0] - 5'(FRAME_BITS) : off_j[4:0];
			qm    = q - 5'd1;
			if (pos_j < {2'b00, pre_q} || off_j >= 19'(DUMMY_FRAME_BITS)) begin
				dummy_bit = 1'b1;
			end else if (q == 5'd0) begin
				dummy_bit = 1'b0;
			end else if (q == 5'(FRAME_BITS - 4'd1)) begin
				dummy_bit = 1'b1;
			end else begin
				dummy_bit = MARK_BYTE[qm[2:0]];
			end
			unique case (run_kind_q)
				RUN_NONE:  run_bit[j] = 1'b0;
				RUN_ZERO:  run_bit[j] = 1'b0;
				RUN_ONE:   run_bit[j] = 1'b1;
				RUN_DUMMY: run_bit[j] = dummy_bit;
			endcase
		end
		for (int i = 0; i < 8; i++) begin
			sel = 4'(i) - kf;
			slot[i] = (4'(i) < kf) ? frame_q[i] : run_bit[sel[2:0]];
		end
		acc = pack_q;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < tk) begin
				acc = {acc[6:0], slot[i]};
			end
		end
	end

	// result of the item at the queue head
	always_comb begin
		res_stat = ST_TAKEN;
		res_byte = 8'h00;
		res_last = 1'b0;
		if (dead) begin
			res_stat = ST_HDR_BAD;
		end else begin
			unique case (q_entry.op)
				OP_BYTE: begin
					if (ended_q || pending) res_stat = ST_BUSY;
					else if (hdr_fail) res_stat = ST_HDR_BAD;
					else res_stat = ST_TAKEN;
				end
				OP_EOF: res_stat = ST_TAKEN;
				OP_PULL: begin
					if (full) begin
						res_stat = ST_VALID;
						res_byte = acc;
						res_last = ended_q && !pend_after;
					end else if (ended_q) begin
						if (cnt_new != 4'd0) begin
							res_stat = ST_VALID;
							res_byte = pad;
							res_last = 1'b1;
						end else begin
							res_stat = ST_EXHAUSTED;
						end
					end else begin
						res_stat = ST_NEED;
					end
				end
				OP_BAD: res_stat = ST_BUSY;
			endcase
		end
	end

	// next state of parser, sources and packer
	always_comb begin
		phase_d      = phase_q;
		idx_d        = idx_q;
		id_d         = id_q;
		left_d       = left_q;
		dur_d        = dur_q;
		ended_d      = ended_q;
		frame_d      = frame_q;
		frame_left_d = frame_left_q;
		run_kind_d   = run_kind_q;
		run_pos_d    = run_pos_q;
		pack_d       = pack_q;
		pack_cnt_d   = pack_cnt_q;
		cv_start     = 1'b0;
		cv_tgt       = CV_ZERO;
		cv_ms        = {b, dur_q[7:0]};
		if (!dead && q_entry.op == OP_EOF) begin
			ended_d = 1'b1;
		end
		if (!dead && q_entry.op == OP_PULL) begin
			frame_d      = frame_q >> kf;
			frame_left_d = frame_left_new;
			run_kind_d   = run_done ? RUN_NONE : run_kind_q;
			run_pos_d    = run_done ? 18'd0 : pos_new;
			if (full || ended_q) begin
				pack_d     = 8'h00;
				pack_cnt_d = 3'd0;
			end else begin
				pack_d     = acc;
				pack_cnt_d = cnt_new[2:0];
			end
		end
		if (!dead && byte_ok) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_fail) begin
						phase_d = PH_DEAD;
					end else if (idx_inc >= HEADER_BYTES) begin
						phase_d = PH_ID;
						idx_d   = 4'd0;
					end else begin
						idx_d = idx_inc;
					end
				end
				PH_ID: begin
					if (idx_q == 4'd0) begin
						id_d  = {8'h00, b};
						idx_d = 4'd1;
					end else begin
						id_d    = {b, id_q[7:0]};
						phase_d = PH_LEN;
						idx_d   = 4'd0;
						left_d  = 32'd0;
					end
				end
				PH_LEN: begin
					left_d = len_new;
					idx_d  = idx_inc;
					if (idx_inc >= 4'd4) begin
						idx_d = 4'd0;
						if (len_new == 32'd0) phase_d = PH_ID;
						else if (id_q == ID_TAPE) phase_d = PH_DATA;
						else if ((id_q == ID_GAP || id_q == ID_TONE) && len_new >= 32'd2)
							phase_d = PH_DUR;
						else if (id_q == ID_DUMMY && len_new >= 32'd4) phase_d = PH_DUR;
						else phase_d = PH_SKIP;
					end
				end
				PH_DATA: begin
					frame_d      = {1'b1, b, 1'b0};
					frame_left_d = FRAME_BITS;
					left_d       = left_dec;
					if (left_dec == 32'd0) begin
						phase_d = PH_ID;
						idx_d   = 4'd0;
					end
				end
				PH_DUR: begin
					dur_d = idx_q[0] ? {b, dur_q[7:0]} : {8'h00, b};
					idx_d = idx_inc;
					if (idx_inc == 4'd2) begin
						cv_start = 1'b1;
						if (id_q == ID_GAP) cv_tgt = CV_ZERO;
						else if (id_q == ID_TONE) cv_tgt = CV_ONE;
						else cv_tgt = CV_PRE;
					end else if (idx_inc == 4'd4) begin
						cv_start = 1'b1;
						cv_tgt   = CV_DUMMY;
					end
					left_d = left_dec;
					if (left_dec == 32'd0) begin
						phase_d = PH_ID;
						idx_d   = 4'd0;
					end else if ((id_q == ID_DUMMY) ? (idx_inc >= 4'd4) : (idx_inc >= 4'd2)) begin
						phase_d = PH_SKIP;
						idx_d   = 4'd0;
					end
				end
				PH_SKIP: begin
					left_d = left_dec;
					if (left_dec == 32'd0) begin
						phase_d = PH_ID;
						idx_d   = 4'd0;
					end
				end
				default: phase_d = PH_DEAD;
			endcase
		end
	end

	// ms to bit count: 21*ms/8 here, reciprocal multiply in s2, add and start in finish
	assign cv_t21       = 21'({cv_ms, 4'b0000}) + 21'({cv_ms, 2'b00}) + 21'(cv_ms);
	assign cv_bits      = {1'b0, conv_ms_s2} + {2'b00, conv_prod_s2[36:RECIP_SHIFT]};
	assign cv_dummy_len = {1'b0, pre_q} + 18'(DUMMY_FRAME_BITS) + {1'b0, cv_bits};

	always_ff @(posedge clk) begin
		conv_ms_s1   <= cv_ms;
		conv_t_s1    <= cv_t21[20:3];
		conv_tgt_s1  <= cv_tgt;
		conv_ms_s2   <= conv_ms_s1;
		conv_prod_s2 <= {19'd0, conv_t_s1} * {18'd0, RECIP_MUL};
		conv_tgt_s2  <= conv_tgt_s1;
		if (q_pop) begin
			m_tdata_q <= res_byte;
			m_tuser_q <= res_stat;
			m_tlast_q <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			idx_q        <= 4'd0;
			id_q         <= 16'd0;
			left_q       <= 32'd0;
			dur_q        <= 16'd0;
			ended_q      <= 1'b0;
			frame_q      <= 10'd0;
			frame_left_q <= 4'd0;
			run_kind_q   <= RUN_NONE;
			run_pos_q    <= 18'd0;
			run_len_q    <= 18'd0;
			pre_q        <= 17'd0;
			pack_q       <= 8'h00;
			pack_cnt_q   <= 3'd0;
			conv_v_s1    <= 1'b0;
			conv_v_s2    <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			conv_v_s1 <= q_pop && cv_start;
			conv_v_s2 <= conv_v_s1;
			if (q_pop) begin
				phase_q      <= phase_d;
				idx_q        <= idx_d;
				id_q         <= id_d;
				left_q       <= left_d;
				dur_q        <= dur_d;
				ended_q      <= ended_d;
				frame_q      <= frame_d;
				frame_left_q <= frame_left_d;
				run_kind_q   <= run_kind_d;
				run_pos_q    <= run_pos_d;
				pack_q       <= pack_d;
				pack_cnt_q   <= pack_cnt_d;
				m_tvalid_q   <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (conv_v_s2) begin
				unique case (conv_tgt_s2)
					CV_ZERO: begin
						run_pos_q  <= 18'd0;
						run_len_q  <= {1'b0, cv_bits};
						run_kind_q <= (cv_bits != 17'd0) ? RUN_ZERO : RUN_NONE;
					end
					CV_ONE: begin
						run_pos_q  <= 18'd0;
						run_len_q  <= {1'b0, cv_bits};
						run_kind_q <= (cv_bits != 17'd0) ? RUN_ONE : RUN_NONE;
					end
					CV_PRE: pre_q <= cv_bits;
					CV_DUMMY: begin
						run_pos_q  <= 18'd0;
						run_len_q  <= cv_dummy_len;
						run_kind_q <= RUN_DUMMY;
					end
				endcase
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

>>> tb/uefb_stream_checker.sv
`timescale 1ns / 1ps
// checker for the tape image to bit stream converter: predicts each status, stream byte and
// last flag from the accepted input transfers and compares them with the output transfers
// depends on uefb_pkg
module uefb_stream_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // file_byte
	input  logic [1:0] s_tuser,   // action
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // out_byte
	input  logic [2:0] m_tuser,   // status
	input  logic       m_tlast,   // last
	output int         errors,
	output int         outstanding
);
	import uefb_pkg::*;

	typedef struct packed {
		stat_t      st;
		logic [7:0] data;
		logic       fin;
	} tape_result_t;

	// "UEF File!" and its terminating nul, first byte lowest
	localparam logic [79:0] UEF_SIGNATURE = 80'h00_21_65_6C_69_46_20_46_45_55;

	tape_result_t tape_results_q[$];
	tape_result_t got_r;

	phase_t      prs_phase;
	logic [3:0]  fld_idx;
	logic        hdr_ok;
	logic [15:0] chunk_id;
	logic [31:0] chunk_left;
	logic [15:0] dur_word;
	run_t        run_sel;
	logic [17:0] run_pos;
	logic [17:0] run_len;
	logic [16:0] lead_bits;
	logic [9:0]  frm_shift;
	logic [3:0]  frm_left;
	logic [7:0]  pack_reg;
	logic [2:0]  pack_cnt;
	logic        eof_seen;

	function automatic logic [17:0] ms_bits(input logic [15:0] ms);
		logic [31:0] p;
		p = {16'd0, ms} * 32'd125;
		return 18'(p / 32'd104);
	endfunction

	function automatic logic bits_waiting();
		return (frm_left != 4'd0) || (run_sel != RUN_NONE);
	endfunction

	function automatic logic next_stream_bit();
		logic        b;
		logic [17:0] lead18;
		logic [17:0] q;
		if (frm_left != 4'd0) begin
			b = frm_shift[0];
			frm_shift = frm_shift >> 1;
			frm_left = frm_left - 4'd1;
			return b;
		end
		lead18 = {1'b0, lead_bits};
		case (run_sel)
			RUN_ZERO: b = 1'b0;
			RUN_ONE:  b = 1'b1;
			default: begin
				// carrier ones around two framed mark bytes
				if (run_pos < lead18 || run_pos >= lead18 + {13'd0, DUMMY_FRAME_BITS}) begin
					b = 1'b1;
				end else begin
					q = (run_pos - lead18) % {14'd0, FRAME_BITS};
					if (q == 18'd0)
						b = 1'b0;
					else if (q == 18'd9)
						b = 1'b1;
					else
						b = MARK_BYTE[3'(q - 18'd1)];
				end
			end
		endcase
		run_pos = run_pos + 18'd1;
		if (run_pos >= run_len) begin
			run_sel = RUN_NONE;
			run_pos = '0;
		end
		return b;
	endfunction

	function automatic void begin_run(input run_t kind, input logic [17:0] len);
		run_pos = '0;
		run_len = len;
		run_sel = (len != 18'd0) ? kind : RUN_NONE;
	endfunction

	function automatic void body_byte_done();
		chunk_left = chunk_left - 32'd1;
		if (chunk_left == 32'd0) begin
			prs_phase = PH_ID;
			fld_idx = '0;
		end
	endfunction

	function automatic void length_complete();
		fld_idx = '0;
		if (chunk_left == 32'd0)
			prs_phase = PH_ID;
		else if (chunk_id == ID_TAPE)
			prs_phase = PH_DATA;
		else if ((chunk_id == ID_GAP || chunk_id == ID_TONE) && chunk_left >= 32'd2)
			prs_phase = PH_DUR;
		else if (chunk_id == ID_DUMMY && chunk_left >= 32'd4)
			prs_phase = PH_DUR;
		else
			prs_phase = PH_SKIP;
	endfunction

	function automatic stat_t parse_file_byte(input logic [7:0] b);
		logic        done;
		logic [17:0] nbits;
		case (prs_phase)
			PH_HEADER: begin
				if (fld_idx < MAGIC_BYTES && b != UEF_SIGNATURE[{fld_idx, 3'b000} +: 8]) begin
					hdr_ok = 1'b0;
					prs_phase = PH_DEAD;
					return ST_HDR_BAD;
				end
				fld_idx = fld_idx + 4'd1;
				if (fld_idx >= HEADER_BYTES) begin
					prs_phase = PH_ID;
					fld_idx = '0;
				end
				return ST_TAKEN;
			end
			PH_ID: begin
				if (fld_idx == 4'd0) begin
					chunk_id = {8'h00, b};
					fld_idx = 4'd1;
				end else begin
					chunk_id = {b, chunk_id[7:0]};
					prs_phase = PH_LEN;
					fld_idx = '0;
					chunk_left = '0;
				end
				return ST_TAKEN;
			end
			PH_LEN: begin
				chunk_left = chunk_left | ({24'd0, b} << (8 * fld_idx[1:0]));
				fld_idx = fld_idx + 4'd1;
				if (fld_idx >= 4'd4)
					length_complete();
				return ST_TAKEN;
			end
			PH_DATA: begin
				frm_shift = {1'b1, b, 1'b0};
				frm_left = FRAME_BITS;
				body_byte_done();
				return ST_TAKEN;
			end
			PH_DUR: begin
				if (!fld_idx[0])
					dur_word = {8'h00, b};
				else
					dur_word = {b, dur_word[7:0]};
				fld_idx = fld_idx + 4'd1;
				if (fld_idx == 4'd2) begin
					nbits = ms_bits(dur_word);
					if (chunk_id == ID_GAP)
						begin_run(RUN_ZERO, nbits);
					else if (chunk_id == ID_TONE)
						begin_run(RUN_ONE, nbits);
					else
						lead_bits = nbits[16:0];
				end else if (fld_idx == 4'd4) begin
					begin_run(RUN_DUMMY, {1'b0, lead_bits} + {13'd0, DUMMY_FRAME_BITS}
						+ ms_bits(dur_word));
				end
				done = (chunk_id == ID_DUMMY) ? (fld_idx >= 4'd4) : (fld_idx >= 4'd2);
				chunk_left = chunk_left - 32'd1;
				if (chunk_left == 32'd0) begin
					prs_phase = PH_ID;
					fld_idx = '0;
				end else if (done) begin
					prs_phase = PH_SKIP;
					fld_idx = '0;
				end
				return ST_TAKEN;
			end
			PH_SKIP: begin
				body_byte_done();
				return ST_TAKEN;
			end
			default: return ST_HDR_BAD;
		endcase
	endfunction

	function automatic tape_result_t predict_result(input op_t op, input logic [7:0] b);
		tape_result_t r;
		logic [7:0]   acc;
		logic [3:0]   cnt;
		r = '{st: ST_TAKEN, data: 8'h00, fin: 1'b0};
		if (prs_phase == PH_DEAD || !hdr_ok) begin
			r.st = ST_HDR_BAD;
		end else begin
			case (op)
				OP_BYTE: begin
					if (eof_seen || bits_waiting())
						r.st = ST_BUSY;
					else
						r.st = parse_file_byte(b);
				end
				OP_EOF: begin
					eof_seen = 1'b1;
					r.st = ST_TAKEN;
				end
				OP_PULL: begin
					acc = pack_reg;
					cnt = {1'b0, pack_cnt};
					while (cnt < 4'd8 && bits_waiting()) begin
						acc = {acc[6:0], next_stream_bit()};
						cnt = cnt + 4'd1;
					end
					if (cnt == 4'd8) begin
						r.st = ST_VALID;
						r.data = acc;
						r.fin = eof_seen && !bits_waiting();
						pack_reg = '0;
						pack_cnt = '0;
					end else if (eof_seen) begin
						if (cnt != 4'd0) begin
							// pad the partial byte with zeros in its low bits
							r.st = ST_VALID;
							r.data = acc << (4'd8 - cnt);
							r.fin = 1'b1;
						end else begin
							r.st = ST_EXHAUSTED;
						end
						pack_reg = '0;
						pack_cnt = '0;
					end else begin
						r.st = ST_NEED;
						pack_reg = acc;
						pack_cnt = cnt[2:0];
					end
				end
				default: r.st = ST_BUSY;
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prs_phase = PH_HEADER;
			fld_idx = '0;
			hdr_ok = 1'b1;
			chunk_id = '0;
			chunk_left = '0;
			dur_word = '0;
			run_sel = RUN_NONE;
			run_pos = '0;
			run_len = '0;
			lead_bits = '0;
			frm_shift = '0;
			frm_left = '0;
			pack_reg = '0;
			pack_cnt = '0;
			eof_seen = 1'b0;
			tape_results_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (tape_results_q.size() == 0) begin
					$error("output transfer with nothing expected: status %0d out_byte %0h last %0d",
						m_tuser, m_tdata, m_tlast);
					errors++;
				end else begin
					got_r = tape_results_q.pop_front();
					if (m_tuser !== got_r.st) begin
						$error("status expected %0d actual %0d", got_r.st, m_tuser);
						errors++;
					end
					if (m_tdata !== got_r.data) begin
						$error("out_byte expected %0h actual %0h", got_r.data, m_tdata);
						errors++;
					end
					if (m_tlast !== got_r.fin) begin
						$error("last expected %0d actual %0d", got_r.fin, m_tlast);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				tape_results_q.push_back(predict_result(op_t'(s_tuser), s_tdata));
			outstanding = tape_results_q.size();
		end
	end

endmodule

>>> tb/uef_chunk_to_tape_bitstream_top_tb.sv
`timescale 1ns / 1ps
// testbench top for the tape image to bit stream converter: feeds one well-formed tape image
// with noise and random back pressure, gives the verdict from the checker's failure count
// depends on uefb_pkg, uefb_stream_checker, uef_chunk_to_tape_bitstream_top
module uef_chunk_to_tape_bitstream_top_tb;
	import uefb_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [79:0] UEF_SIGNATURE = 80'h00_21_65_6C_69_46_20_46_45_55;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic [1:0] s_tuser = 2'd0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	int   fail_count;
	int   pending_results;
	int   sent = 0;
	int   cycles = 0;
	int   src_idle_pct = 0;
	int   snk_stall_pct = 0;
	int   hold_left = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	always #5 clk = ~clk;

	uef_chunk_to_tape_bitstream_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	uefb_stream_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.errors      (fail_count),
		.outstanding (pending_results)
	);

	// receiver: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int carrier_bits(input logic [15:0] ms);
		return (int'(ms) * 125) / 104;
	endfunction

	function automatic logic [15:0] pick_ms();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 16'd0;
		else if (r < 75)
			return 16'($urandom_range(1, 40));
		else if (r < 95)
			return 16'($urandom_range(41, 300));
		return 16'($urandom_range(301, 1500));
	endfunction

	task automatic put_action(input op_t op, input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic maybe_noise();
		if ($urandom_range(99) < 5)
			put_action(OP_BAD, 8'($urandom));
		if ($urandom_range(99) < 5)
			put_action(OP_PULL, 8'($urandom));
	endtask

	// one image byte, then pulls until the bits it starts are drained
	task automatic feed(input logic [7:0] b, input int nbits);
		maybe_noise();
		put_action(OP_BYTE, b);
		if (nbits > 0) begin
			if ($urandom_range(99) < 15)
				put_action(OP_BYTE, 8'($urandom));
			repeat ((nbits + 7) / 8 + 1) begin
				maybe_noise();
				put_action(OP_PULL, 8'($urandom));
			end
		end
	endtask

	task automatic put_chunk_head(input logic [15:0] id, input logic [31:0] len);
		feed(id[7:0], 0);
		feed(id[15:8], 0);
		for (int i = 0; i < 4; i++)
			feed(len[8*i +: 8], 0);
	endtask

	task automatic random_chunk();
		int          kind;
		int          len;
		int          extra;
		logic [15:0] id;
		logic [15:0] ms;
		logic [15:0] ms2;
		kind = $urandom_range(99);
		extra = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
		if (kind < 35) begin
			len = $urandom_range(1, 8);
			put_chunk_head(ID_TAPE, 32'(len));
			repeat (len)
				feed(8'($urandom), 10);
		end else if (kind < 60) begin
			id = $urandom_range(1) ? ID_GAP : ID_TONE;
			ms = pick_ms();
			put_chunk_head(id, 32'(2 + extra));
			feed(ms[7:0], 0);
			feed(ms[15:8], carrier_bits(ms));
			repeat (extra)
				feed(8'($urandom), 0);
		end else if (kind < 78) begin
			ms = pick_ms();
			ms2 = pick_ms();
			put_chunk_head(ID_DUMMY, 32'(4 + extra));
			feed(ms[7:0], 0);
			feed(ms[15:8], 0);
			feed(ms2[7:0], 0);
			feed(ms2[15:8], carrier_bits(ms) + 20 + carrier_bits(ms2));
			repeat (extra)
				feed(8'($urandom), 0);
		end else if (kind < 86) begin
			// duration chunk too short to hold its words
			case ($urandom_range(2))
				0: begin id = ID_GAP; len = $urandom_range(0, 1); end
				1: begin id = ID_TONE; len = $urandom_range(0, 1); end
				default: begin id = ID_DUMMY; len = $urandom_range(0, 3); end
			endcase
			put_chunk_head(id, 32'(len));
			repeat (len)
				feed(8'($urandom), 0);
		end else begin
			id = $urandom_range(1) ? {8'h01, 8'($urandom)} : 16'($urandom);
			if (id == ID_TAPE || id == ID_TONE || id == ID_DUMMY || id == ID_GAP)
				id = 16'h0200;
			len = $urandom_range(0, 5);
			put_chunk_head(id, 32'(len));
			repeat (len)
				feed(8'($urandom), 0);
		end
	endtask

	initial begin
		int target;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_action(OP_BAD, 8'hFF);
		put_action(OP_PULL, 8'h00);
		for (int i = 0; i < 10; i++)
			put_action(OP_BYTE, UEF_SIGNATURE[7'(8*i) +: 8]);
		put_action(OP_BYTE, 8'hFF);
		put_action(OP_BYTE, 8'h00);
		put_chunk_head(ID_TAPE, 32'd2);
		put_action(OP_BYTE, 8'h00);
		put_action(OP_BYTE, 8'hA5);
		repeat (2) put_action(OP_PULL, 8'hFF);
		put_action(OP_BYTE, 8'hFF);
		repeat (2) put_action(OP_PULL, 8'h00);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct <= 0; snk_stall_pct <= 0; hold_req <= 1'b1; end
				1: begin src_idle_pct <= 75; snk_stall_pct <= 0; end
				2: begin src_idle_pct <= 0; snk_stall_pct <= 75; end
				default: begin src_idle_pct <= 37; snk_stall_pct <= 37; end
			endcase
			target = sent + RANDOM_ITEMS / 4;
			while (sent < target)
				random_chunk();
		end

		// tone whose duration uses both bytes of the word
		src_idle_pct <= 0;
		snk_stall_pct <= 0;
		put_chunk_head(ID_TONE, 32'd2);
		feed(8'hFF, 0);
		feed(8'h01, carrier_bits(16'h01FF));

		// end of file inside a tape chunk, then drain and poke the ended stream
		snk_stall_pct <= 37;
		put_chunk_head(ID_TAPE, 32'd3);
		put_action(OP_BYTE, 8'h3C);
		put_action(OP_EOF, 8'h00);
		repeat (4) put_action(OP_PULL, 8'h00);
		put_action(OP_BYTE, 8'h81);
		put_action(OP_EOF, 8'hFF);
		put_action(OP_BAD, 8'h00);
		put_action(OP_PULL, 8'hFF);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
